// ===== rtl/core/dheap_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the d-ary min-heap core
package dheap_pkg;

  localparam int unsigned KEY_W     = 32;
  localparam int unsigned ARITY_W   = 4;
  localparam int unsigned ARITY_MIN = 2;

  localparam logic [ARITY_W-1:0] ARITY_RST = 4'd3;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // action codes of an input word
  localparam logic ACT_INSERT  = 1'b0;
  localparam logic ACT_EXTRACT = 1'b1;

  // operation of the shared multiplier
  typedef enum logic {
    MUL_PARENT = 1'b0,
    MUL_CHILD  = 1'b1
  } mul_op_e;

  typedef struct packed {
    logic    mul_en;
    mul_op_e mul_op;
  } unit_ctrl_t;

endpackage

// ===== rtl/core/d_ary_min_heap_core.sv =====
`timescale 1ns / 1ps
// d-ary min-heap priority queue core: insert sifts the new key up level by level,
// extract moves the last key to the root and sifts it down level by level;
// each level is bounded by the single ram read port and the shared multiplier/comparator;
// a full insert or an empty extract only reports its status, an extract of the last key skips the sift
// one word in flight: next word accepted once the sequencer is back in idle
// reset clears the entry count, output valid and sets arity to 3; heap ram is never cleared
module d_ary_min_heap_core #(
  parameter int unsigned CAPACITY  = 64,
  parameter int unsigned MAX_ARITY = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // input words
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  action_i,
  input  logic signed [dheap_pkg::KEY_W-1:0]    key_i,
  // result words
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [1:0]                            status_o,
  output logic signed [dheap_pkg::KEY_W-1:0]    removed_key_o,
  output logic [$clog2(CAPACITY+1)-1:0]         occupancy_o,
  // arity register
  input  logic                                  cfg_we_i,
  input  logic [dheap_pkg::ARITY_W-1:0]         cfg_wdata_i
);

  localparam int unsigned AW  = $clog2(CAPACITY);       // ram address
  localparam int unsigned CW  = $clog2(CAPACITY + 1);   // entry count
  localparam int unsigned L   = $clog2(MAX_ARITY);
  localparam int unsigned DW  = $clog2(MAX_ARITY + 1);  // effective arity
  localparam int unsigned S   = AW + L;                 // reciprocal shift
  localparam int unsigned PW  = AW + S;                 // product width
  localparam int unsigned CIW = AW + L + 1;             // child index, may pass the end
  localparam int unsigned KW  = dheap_pkg::KEY_W;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_UP_MUL  = 11'b000_0000_0010,
    S_UP_RD   = 11'b000_0000_0100,
    S_UP_CMP  = 11'b000_0000_1000,
    S_EX_ROOT = 11'b000_0001_0000,
    S_EX_LAST = 11'b000_0010_0000,
    S_DN_MUL  = 11'b000_0100_0000,
    S_DN_CHK  = 11'b000_1000_0000,
    S_DN_SCAN = 11'b001_0000_0000,
    S_DN_CMP  = 11'b010_0000_0000,
    S_DONE    = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  // control state
  logic [CW-1:0]                 count_q, count_d;
  logic [dheap_pkg::ARITY_W-1:0] arity_q;
  logic                          out_valid_q, out_valid_d;

  // working registers
  logic [AW-1:0]  pos_q, pos_d;
  logic [KW-1:0]  tmp_q, tmp_d;
  logic [AW-1:0]  par_q, par_d;
  logic [CIW-1:0] c_q, c_d;
  logic [DW-1:0]  k_q, k_d;
  logic [KW-1:0]  best_val_q, best_val_d;
  logic [AW-1:0]  best_idx_q, best_idx_d;
  logic [1:0]     res_status_q, res_status_d;
  logic [KW-1:0]  res_removed_q, res_removed_d;

  // output register
  logic           load_out;
  logic [1:0]     out_status_q;
  logic [KW-1:0]  out_removed_q;
  logic [CW-1:0]  out_occ_q;

  // effective arity, clamped to 2..MAX_ARITY
  logic [DW-1:0]  arity_eff;

  // ram port
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [KW-1:0]  ram_wdata;
  logic [AW-1:0]  ram_raddr;
  logic [KW-1:0]  ram_rdata;

  // shared unit
  dheap_pkg::unit_ctrl_t unit_ctrl;
  logic [PW-1:0]  prod;
  logic           less;
  logic [KW-1:0]  cmp_a, cmp_b;

  logic [AW-1:0]  parent;
  logic [CIW-1:0] first_child;
  logic [CIW-1:0] next_child;

  assign parent      = prod[S +: AW];
  assign first_child = prod[CIW-1:0] + 1'b1;
  assign next_child  = c_q + 1'b1;

  always_comb begin
    if (int'(arity_q) < dheap_pkg::ARITY_MIN) begin
      arity_eff = DW'(dheap_pkg::ARITY_MIN);
    end else if (int'(arity_q) > MAX_ARITY) begin
      arity_eff = DW'(MAX_ARITY);
    end else begin
      arity_eff = DW'(arity_q);
    end
  end

  dheap_ram #(
    .WIDTH (KW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  dheap_unit #(
    .AW        (AW),
    .MAX_ARITY (MAX_ARITY)
  ) u_unit (
    .clk_i   (clk_i),
    .ctrl_i  (unit_ctrl),
    .pos_i   (pos_q),
    .arity_i (arity_eff),
    .cmp_a_i (cmp_a),
    .cmp_b_i (cmp_b),
    .prod_o  (prod),
    .less_o  (less)
  );

  assign in_ready_o = (state_q == S_IDLE);

  // sequencer
  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    pos_d         = pos_q;
    tmp_d         = tmp_q;
    par_d         = par_q;
    c_d           = c_q;
    k_d           = k_q;
    best_val_d    = best_val_q;
    best_idx_d    = best_idx_q;
    res_status_d  = res_status_q;
    res_removed_d = res_removed_q;
    load_out      = 1'b0;
    unit_ctrl     = '{mul_en: 1'b0, mul_op: dheap_pkg::MUL_PARENT};
    ram_we        = 1'b0;
    ram_waddr     = pos_q;
    ram_wdata     = tmp_q;
    ram_raddr     = '0;      // idle keeps the root on the read port
    cmp_a         = tmp_q;
    cmp_b         = ram_rdata;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_status_d  = dheap_pkg::ST_OK;
          res_removed_d = '0;
          if (action_i == dheap_pkg::ACT_INSERT) begin
            if (count_q == CW'(CAPACITY)) begin
              res_status_d = dheap_pkg::ST_FULL;
              state_d      = S_DONE;
            end else begin
              tmp_d   = key_i;
              pos_d   = count_q[AW-1:0];
              count_d = count_q + 1'b1;
              state_d = S_UP_MUL;
            end
          end else if (count_q == '0) begin
            res_status_d = dheap_pkg::ST_EMPTY;
            state_d      = S_DONE;
          end else begin
            count_d = count_q - 1'b1;
            state_d = S_EX_ROOT;
          end
        end
      end

      // sift up: parent = (pos - 1) / d through the reciprocal multiply
      S_UP_MUL: begin
        if (pos_q == '0) begin
          ram_we  = 1'b1;
          state_d = S_DONE;
        end else begin
          unit_ctrl = '{mul_en: 1'b1, mul_op: dheap_pkg::MUL_PARENT};
          state_d   = S_UP_RD;
        end
      end

      S_UP_RD: begin
        ram_raddr = parent;
        par_d     = parent;
        state_d   = S_UP_CMP;
      end

      S_UP_CMP: begin
        cmp_a  = tmp_q;
        cmp_b  = ram_rdata;
        ram_we = 1'b1;
        if (less) begin
          ram_wdata = ram_rdata;
          pos_d     = par_q;
          state_d   = S_UP_MUL;
        end else begin
          state_d = S_DONE;
        end
      end

      // root arrives; fetch the last entry unless the heap is now empty
      S_EX_ROOT: begin
        res_removed_d = ram_rdata;
        if (count_q == '0) begin
          state_d = S_DONE;
        end else begin
          ram_raddr = count_q[AW-1:0];
          state_d   = S_EX_LAST;
        end
      end

      S_EX_LAST: begin
        tmp_d   = ram_rdata;
        pos_d   = '0;
        state_d = S_DN_MUL;
      end

      // sift down: first child = d * pos + 1
      S_DN_MUL: begin
        unit_ctrl = '{mul_en: 1'b1, mul_op: dheap_pkg::MUL_CHILD};
        state_d   = S_DN_CHK;
      end

      S_DN_CHK: begin
        if (first_child >= CIW'(count_q)) begin
          ram_we  = 1'b1;
          state_d = S_DONE;
        end else begin
          c_d       = first_child;
          k_d       = DW'(1);
          ram_raddr = first_child[AW-1:0];
          state_d   = S_DN_SCAN;
        end
      end

      // one child per cycle; strict less keeps the lowest index on ties
      S_DN_SCAN: begin
        cmp_a = ram_rdata;
        cmp_b = best_val_q;
        if (k_q == DW'(1) || less) begin
          best_val_d = ram_rdata;
          best_idx_d = c_q[AW-1:0];
        end
        if (k_q < arity_eff && next_child < CIW'(count_q)) begin
          ram_raddr = next_child[AW-1:0];
          c_d       = next_child;
          k_d       = k_q + 1'b1;
        end else begin
          state_d = S_DN_CMP;
        end
      end

      S_DN_CMP: begin
        cmp_a  = best_val_q;
        cmp_b  = tmp_q;
        ram_we = 1'b1;
        if (less) begin
          ram_wdata = best_val_q;
          pos_d     = best_idx_q;
          state_d   = S_DN_MUL;
        end else begin
          state_d = S_DONE;
        end
      end

      // wait for the output register to free up
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      arity_q     <= dheap_pkg::ARITY_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        arity_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q         <= pos_d;
    tmp_q         <= tmp_d;
    par_q         <= par_d;
    c_q           <= c_d;
    k_q           <= k_d;
    best_val_q    <= best_val_d;
    best_idx_q    <= best_idx_d;
    res_status_q  <= res_status_d;
    res_removed_q <= res_removed_d;
    if (load_out) begin
      out_status_q  <= res_status_q;
      out_removed_q <= res_removed_q;
      out_occ_q     <= count_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign removed_key_o = out_removed_q;
  assign occupancy_o   = out_occ_q;

`ifndef SYNTHESIS
  // entry count never passes the store size
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // every ram write lands on a live slot
  a_write_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (CW'(ram_waddr) < count_q))
    else $error("heap write beyond entry count");

  // reciprocal divide must give a parent strictly above the node
  a_parent_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UP_RD) |-> (parent < pos_q))
    else $error("parent index not below node index");

  // a successful extract takes exactly one entry
  a_extract_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && action_i == dheap_pkg::ACT_EXTRACT && count_q != '0)
    |=> (count_q == $past(count_q) - 1'b1))
    else $error("extract did not decrement entry count");
`endif

endmodule

// ===== rtl/core/dheap_ram.sv =====
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
module dheap_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/dheap_unit.sv =====
`timescale 1ns / 1ps
// shared multiplier (parent and first-child index) and signed key comparator
module dheap_unit #(
  parameter int unsigned AW        = 6,
  parameter int unsigned MAX_ARITY = 8
) (
  input  logic                                     clk_i,
  input  dheap_pkg::unit_ctrl_t                    ctrl_i,
  input  logic [AW-1:0]                            pos_i,
  input  logic [$clog2(MAX_ARITY+1)-1:0]           arity_i,
  input  logic [dheap_pkg::KEY_W-1:0]              cmp_a_i,
  input  logic [dheap_pkg::KEY_W-1:0]              cmp_b_i,
  output logic [2*AW+$clog2(MAX_ARITY)-1:0]        prod_o,
  output logic                                     less_o
);

  localparam int unsigned L  = $clog2(MAX_ARITY);
  localparam int unsigned S  = AW + L;
  localparam int unsigned PW = AW + S;

  logic [S-1:0]  rcp_tab [MAX_ARITY+1];
  logic [AW-1:0] mul_a;
  logic [S-1:0]  mul_b;
  logic [PW-1:0] prod_q;

  // reciprocal ceil(2^S / d): (x * rcp) >> S is exact for x < 2^AW
  for (genvar k = 0; k <= MAX_ARITY; k++) begin : g_rcp
    if (k < 2) begin : g_unused
      assign rcp_tab[k] = '0;
    end else begin : g_entry
      localparam longint unsigned RCP = ((64'd1 << S) + k - 1) / k;
      assign rcp_tab[k] = S'(RCP);
    end
  end

  always_comb begin
    if (ctrl_i.mul_op == dheap_pkg::MUL_PARENT) begin
      mul_a = pos_i - 1'b1;
      mul_b = rcp_tab[arity_i];
    end else begin
      mul_a = pos_i;
      mul_b = S'(arity_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= PW'(mul_a) * PW'(mul_b);
    end
  end

  assign prod_o = prod_q;
  assign less_o = $signed(cmp_a_i) < $signed(cmp_b_i);

endmodule

// ===== dv/d_ary_min_heap_checker.sv =====
`timescale 1ns / 1ps
// result checker for the d-ary min-heap core: tracks the heap contents and compares every result word
module d_ary_min_heap_checker #(
  parameter int unsigned CAPACITY  = 64,
  parameter int unsigned MAX_ARITY = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  input  logic                                  in_ready_i,
  input  logic                                  action_i,
  input  logic signed [dheap_pkg::KEY_W-1:0]    key_i,
  input  logic                                  out_valid_i,
  input  logic                                  out_ready_i,
  input  logic [1:0]                            status_i,
  input  logic signed [dheap_pkg::KEY_W-1:0]    removed_key_i,
  input  logic [$clog2(CAPACITY+1)-1:0]         occupancy_i,
  input  logic                                  cfg_we_i,
  input  logic [dheap_pkg::ARITY_W-1:0]         cfg_wdata_i,
  output int                                    fail_count_o,
  output int unsigned                           pending_count_o
);

  localparam int unsigned OCC_W = $clog2(CAPACITY+1);

  typedef struct {
    logic [1:0]                          status;
    logic signed [dheap_pkg::KEY_W-1:0]  removed_key;
    logic [OCC_W-1:0]                    occupancy;
  } heap_result_t;

  // shadow copy of the heap
  logic signed [dheap_pkg::KEY_W-1:0] heap_keys [CAPACITY];
  int unsigned                        key_count;
  logic [dheap_pkg::ARITY_W-1:0]      arity_q;

  heap_result_t                       pending_results [$];

  // apply one insert or extract to the shadow heap and return the result word
  function automatic heap_result_t heap_apply(input logic act,
                                             input logic signed [dheap_pkg::KEY_W-1:0] key_in);
    heap_result_t                       res;
    int unsigned                        d, pos, par, first, best, c, k;
    logic signed [dheap_pkg::KEY_W-1:0] moving;
    res.status      = dheap_pkg::ST_OK;
    res.removed_key = '0;
    if (arity_q < dheap_pkg::ARITY_MIN) d = dheap_pkg::ARITY_MIN;
    else if (arity_q > MAX_ARITY) d = MAX_ARITY;
    else d = arity_q;

    if (act == dheap_pkg::ACT_INSERT) begin
      if (key_count >= CAPACITY) begin
        res.status = dheap_pkg::ST_FULL;
      end else begin
        pos = key_count;
        key_count++;
        // sift up past strictly larger parents
        while (pos > 0) begin
          par = (pos - 1) / d;
          if (!(key_in < heap_keys[par])) break;
          heap_keys[pos] = heap_keys[par];
          pos = par;
        end
        heap_keys[pos] = key_in;
      end
    end else begin
      if (key_count == 0) begin
        res.status = dheap_pkg::ST_EMPTY;
      end else begin
        res.removed_key = heap_keys[0];
        key_count--;
        if (key_count > 0) begin
          moving = heap_keys[key_count];
          pos = 0;
          // sift down: smallest child wins, lowest index on ties
          forever begin
            first = d * pos + 1;
            if (first >= key_count) break;
            best = first;
            for (k = 2; k <= d; k++) begin
              c = d * pos + k;
              if (c >= key_count) break;
              if (heap_keys[c] < heap_keys[best]) best = c;
            end
            if (!(heap_keys[best] < moving)) break;
            heap_keys[pos] = heap_keys[best];
            pos = best;
          end
          heap_keys[pos] = moving;
        end
      end
    end
    res.occupancy = OCC_W'(key_count);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    heap_result_t want;
    if (!rst_ni) begin
      key_count = 0;
      arity_q   = dheap_pkg::ARITY_RST;
      pending_results.delete();
      pending_count_o = 0;
      fail_count_o    = 0;
    end else begin
      if (cfg_we_i) arity_q = cfg_wdata_i;
      if (out_valid_i && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $error("result word with nothing pending: status %0d key %0d occupancy %0d",
                 status_i, removed_key_i, occupancy_i);
          fail_count_o++;
        end else begin
          want = pending_results.pop_front();
          if (status_i !== want.status) begin
            $error("status: expected %0d actual %0d", want.status, status_i);
            fail_count_o++;
          end
          if (removed_key_i !== want.removed_key) begin
            $error("removed_key: expected %0d actual %0d", want.removed_key, removed_key_i);
            fail_count_o++;
          end
          if (occupancy_i !== want.occupancy) begin
            $error("occupancy: expected %0d actual %0d", want.occupancy, occupancy_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) pending_results.push_back(heap_apply(action_i, key_i));
      pending_count_o = pending_results.size();
    end
  end

endmodule

// ===== dv/tb_d_ary_min_heap_core.sv =====
`timescale 1ns / 1ps
// testbench top for the d-ary min-heap core: stimulus, flow control and verdict
module tb_d_ary_min_heap_core;

  localparam int unsigned CAPACITY  = 64;
  localparam int unsigned MAX_ARITY = 8;
  localparam int unsigned OCC_W     = $clog2(CAPACITY+1);
  localparam int unsigned KEY_W     = dheap_pkg::KEY_W;
  localparam int unsigned ARITY_W   = dheap_pkg::ARITY_W;

  // receiver hold-off window and the calm stretches, in cycles after reset / in words
  localparam int unsigned HOLD_START = 2000;
  localparam int unsigned HOLD_LEN   = 400;
  localparam int unsigned CALM_START = 10000;
  localparam int unsigned CALM_END   = 16000;
  localparam int unsigned QUIET_FROM = 600;
  localparam int unsigned QUIET_TO   = 900;

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_ready_o;
  logic                      action_i    = dheap_pkg::ACT_INSERT;
  logic signed [KEY_W-1:0]   key_i       = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [1:0]                status_o;
  logic signed [KEY_W-1:0]   removed_key_o;
  logic [OCC_W-1:0]          occupancy_o;
  logic                      cfg_we_i    = 1'b0;
  logic [ARITY_W-1:0]        cfg_wdata_i = '0;

  int                        fail_count;
  int unsigned               pending_count;
  int unsigned               words_sent  = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  d_ary_min_heap_core #(
    .CAPACITY  (CAPACITY),
    .MAX_ARITY (MAX_ARITY)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .key_i         (key_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .removed_key_o (removed_key_o),
    .occupancy_o   (occupancy_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  d_ary_min_heap_checker #(
    .CAPACITY  (CAPACITY),
    .MAX_ARITY (MAX_ARITY)
  ) heap_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .action_i        (action_i),
    .key_i           (key_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_i        (status_o),
    .removed_key_i   (removed_key_o),
    .occupancy_i     (occupancy_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .fail_count_o    (fail_count),
    .pending_count_o (pending_count)
  );

  // key mix: mostly full-range, plenty of small values for ties, and the extremes
  function automatic logic signed [KEY_W-1:0] pick_key();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      case ($urandom_range(0, 3))
        0:       return 32'h7FFF_FFFF;
        1:       return 32'h8000_0000;
        2:       return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end else if (sel == 1) begin
      if ($urandom_range(0, 1)) return 32'h8000_0000 + $urandom_range(0, 3);
      else return 32'h7FFF_FFFF - $urandom_range(0, 3);
    end else if (sel <= 3) begin
      return KEY_W'(int'($urandom_range(0, 7)) - 4);
    end
    return $urandom;
  endfunction

  // present one word and hold it until the core takes it
  task automatic send_word(input logic act, input logic signed [KEY_W-1:0] k);
    @(negedge clk_i);
    in_valid_i = 1'b1;
    action_i   = act;
    key_i      = k;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
  endtask

  // random gap after a word, skipped during the quiet stretch
  task automatic maybe_idle();
    if ((words_sent < QUIET_FROM || words_sent >= QUIET_TO) && $urandom_range(0, 1)) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat ($urandom_range(0, 8)) @(negedge clk_i);
    end
  endtask

  task automatic send_mix(input int unsigned count, input int unsigned insert_pct);
    for (int unsigned i = 0; i < count; i++) begin
      send_word(($urandom_range(0, 99) < insert_pct) ? dheap_pkg::ACT_INSERT
                                                     : dheap_pkg::ACT_EXTRACT, pick_key());
      maybe_idle();
    end
  endtask

  // arity changes only once every result is back and the core has settled
  task automatic write_arity(input logic [ARITY_W-1:0] value);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_wdata_i = value;
    cfg_we_i    = 1'b1;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  // receiver: random stalls, one long hold-off so the core backs up, one calm stretch
  initial begin
    int unsigned cyc;
    cyc = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN) out_ready_i = 1'b0;
      else if (cyc >= CALM_START && cyc < CALM_END) out_ready_i = 1'b1;
      else out_ready_i = ($urandom_range(0, 99) >= 10);
    end
  end

  initial begin
    logic [ARITY_W-1:0] arity_plan [10];
    // in-range, clamped-low and clamped-high arities, reset value last
    arity_plan = '{4'd2, 4'd8, 4'd0, 4'd15, 4'd4, 4'd1, 4'd9, 4'd5, 4'd7, 4'd3};
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty extract, extremes, duplicate keys, drain past empty (reset arity)
    send_word(dheap_pkg::ACT_EXTRACT, 32'h1234_5678);
    send_word(dheap_pkg::ACT_INSERT, 32'h7FFF_FFFF);
    send_word(dheap_pkg::ACT_INSERT, 32'h8000_0000);
    send_word(dheap_pkg::ACT_INSERT, 32'h0000_0000);
    send_word(dheap_pkg::ACT_INSERT, 32'hFFFF_FFFF);
    send_word(dheap_pkg::ACT_INSERT, 32'h0000_0001);
    send_word(dheap_pkg::ACT_INSERT, 32'sd5);
    send_word(dheap_pkg::ACT_INSERT, 32'sd5);
    send_word(dheap_pkg::ACT_INSERT, 32'hFFFF_FFFF);
    send_word(dheap_pkg::ACT_INSERT, 32'sd5);
    send_word(dheap_pkg::ACT_INSERT, 32'h8000_0000);
    repeat (11) send_word(dheap_pkg::ACT_EXTRACT, 32'hFFFF_FFFF);

    // per arity: drain to empty, fill past full, then a balanced mix so the
    // next arity change lands on a populated heap
    foreach (arity_plan[p]) begin
      write_arity(arity_plan[p]);
      send_mix(85, 10);
      send_mix(85, 90);
      send_mix(20, 50);
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("d_ary_min_heap_core test passed");
    end else begin
      $display("d_ary_min_heap_core test failed");
    end
    $finish;
  end

  // run limit, several times the slowest legal run
  initial begin
    #5_000_000;
    $display("d_ary_min_heap_core test failed");
    $finish;
  end

endmodule
